// File: src/gbm_pkg.sv
// Shared types, constants and the 2^x table builder for the GBM path step block.
// Used by every module of the block; depends on nothing.
`default_nettype none

package gbm_pkg;

    localparam int EXP_TABLE_ENTRIES = 256;
    localparam int PRICE_FRAC_BITS   = 16;

    localparam int TBL_IDX_W  = $clog2(EXP_TABLE_ENTRIES);
    localparam int TBL_ADDR_W = TBL_IDX_W + 1;
    localparam int FRAC_W     = 28 - TBL_IDX_W;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam int MUL_A_W = 33;
    localparam int MUL_B_W = 32;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    localparam logic [31:0] INIT_PRICE_RST = 32'(100 << PRICE_FRAC_BITS);
    localparam logic [15:0] STEPS_RST      = 16'd256;
    localparam logic [30:0] LOG2E_Q30      = 31'd1549082005;
    localparam logic [31:0] PRICE_MAX      = 32'hFFFF_FFFF;

    localparam logic signed [36:0] W_LIMIT     = 37'sd6174015488;
    localparam logic signed [36:0] W_LIMIT_NEG = -37'sd6174015488;

    localparam logic [127:0] LN2_Q60    = 128'h0B17217F7D1CF79B;
    localparam logic [127:0] ONE_Q60    = 128'd1 << 60;
    localparam logic [127:0] LN2_STEP_Q = LN2_Q60 / EXP_TABLE_ENTRIES;
    localparam logic [127:0] LN2_STEP_R = LN2_Q60 % EXP_TABLE_ENTRIES;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INIT_PRICE = 2'd0,
        CFG_DRIFT      = 2'd1,
        CFG_DIFFUSION  = 2'd2,
        CFG_STEPS      = 2'd3
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIFF,
        S_WSUM,
        S_LOG,
        S_SPLIT,
        S_ROM_LO,
        S_ROM_HI,
        S_INTERP,
        S_MANT,
        S_PRICE,
        S_SHIFT
    } t_gbm_state;

    typedef struct packed {
        logic               en;
        logic [MUL_A_W-1:0] a;
        logic [MUL_B_W-1:0] b;
    } t_mul_req;

    // 2^(i/N) in Q2.30 from a 25-term series of exp(i*ln2/N) in Q.60, rounded
    function automatic logic [31:0] pow2_entry(input logic [12:0] i);
        logic [127:0] y;
        logic [127:0] term;
        logic [127:0] sum;
        logic [127:0] prod;
        logic [127:0] rnd;
        int           k;
        y    = LN2_STEP_Q * 128'(i) + (LN2_STEP_R * 128'(i)) / EXP_TABLE_ENTRIES;
        term = ONE_Q60;
        sum  = ONE_Q60;
        for (k = 1; k <= 24; k++) begin
            prod = term * y;
            term = (prod >> 60) / 128'(k);
            sum  = sum + term;
        end
        rnd = (sum + (128'd1 << 29)) >> 30;
        if (32'(i) == EXP_TABLE_ENTRIES) begin
            return 32'h8000_0000;
        end
        return rnd[31:0];
    endfunction

endpackage

`default_nettype wire

// File: src/gbm_sample_if.sv
// Input channel of the GBM path step block: one normal sample per transfer.
// Depends on nothing.
`default_nettype none

interface gbm_sample_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] normal_sample;

    modport source (output valid, output normal_sample, input ready);
    modport sink   (input valid, input normal_sample, output ready);
endinterface

`default_nettype wire

// File: src/gbm_result_if.sv
// Output channel of the GBM path step block: one price step per transfer.
// Depends on nothing.
`default_nettype none

interface gbm_result_if;
    logic        valid;
    logic        ready;
    logic [31:0] price;
    logic [15:0] step_index;
    logic        last_of_path;
    logic        saturated;

    modport source (output valid, output price, output step_index, output last_of_path,
                    output saturated, input ready);
    modport sink   (input valid, input price, input step_index, input last_of_path,
                    input saturated, output ready);
endinterface

`default_nettype wire

// File: src/gbm_mul.sv
// Shared unsigned multiplier with a registered product, reused by the sequencer.
// Depends on gbm_pkg.
`default_nettype none

module gbm_mul (
    input  wire logic                      i_clk,
    input  wire gbm_pkg::t_mul_req         i_req,
    output logic [gbm_pkg::MUL_P_W-1:0]    o_prod
);
    import gbm_pkg::*;

    logic [MUL_P_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (i_req.en) begin
            r_prod <= MUL_P_W'(i_req.a) * MUL_P_W'(i_req.b);
        end
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

// File: src/gbm_pow2_rom.sv
// Constant 2^(i/N) table in Q2.30 with a registered read port.
// Depends on gbm_pkg.
`default_nettype none

module gbm_pow2_rom (
    input  wire logic                          i_clk,
    input  wire logic [gbm_pkg::TBL_ADDR_W-1:0] i_addr,
    output logic [31:0]                        o_data
);
    import gbm_pkg::*;

    logic [31:0] w_tbl [EXP_TABLE_ENTRIES+1];
    logic [31:0] r_data;

    for (genvar g = 0; g <= EXP_TABLE_ENTRIES; g++) begin : g_entry
        localparam logic [31:0] ENTRY = pow2_entry(13'(g));
        assign w_tbl[g] = ENTRY;
    end

    always_ff @(posedge i_clk) begin
        if (32'(i_addr) <= EXP_TABLE_ENTRIES) begin
            r_data <= w_tbl[i_addr];
        end else begin
            r_data <= '0;
        end
    end

    assign o_data = r_data;

endmodule

`default_nettype wire

// File: src/gbm_path_step.sv
// Steps one sample at a time: a new sample is taken only in the idle state, after the
// result of the last one is loaded, later if the result register is stalled.
// The sequence is set by the single shared multiplier (four products per step) and
// two reads of the 2^x table port, one operation per cycle unless the result stalls.
// Reset (synchronous, active low) clears the sequencer, output valid and step count,
// and loads the configuration registers and current price with their reset values.
`default_nettype none

module gbm_path_step (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [gbm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [gbm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    gbm_sample_if.sink                         i_sample,
    gbm_result_if.source                       o_result
);
    import gbm_pkg::*;

    t_gbm_state r_state, n_state;

    logic [31:0]        r_init_price;
    logic signed [31:0] r_drift;
    logic [30:0]        r_diffusion;
    logic [15:0]        r_steps;

    logic signed [15:0] r_z;
    logic               r_neg;
    logic [32:0]        r_mag;
    logic signed [6:0]  r_k;
    logic [27:0]        r_f;
    logic [31:0]        r_lo;
    logic [31:0]        r_mant;
    logic [31:0]        r_cur_price;
    logic [15:0]        r_step_cnt;

    logic        r_out_valid;
    logic [31:0] r_out_price;
    logic [15:0] r_out_step;
    logic        r_out_last;
    logic        r_out_sat;

    t_mul_req           mul_req;
    logic [MUL_P_W-1:0] mul_prod;
    logic [TBL_ADDR_W-1:0] rom_addr;
    logic [31:0]        rom_data;

    logic               in_xfer;
    logic               out_free;
    logic               out_load;

    logic [16:0]        z_ext;
    logic [16:0]        z_abs;
    logic signed [47:0] prod_s;
    logic signed [47:0] prod_sh;
    logic signed [36:0] w_sum;
    logic signed [36:0] w_abs;
    logic               w_neg;
    logic [32:0]        w_mag;
    logic [6:0]         k_mag;
    logic [27:0]        f_raw;
    logic signed [6:0]  k_val;
    logic [27:0]        f_val;
    logic [TBL_ADDR_W-1:0] tbl_idx;
    logic [31:0]        tbl_diff;
    logic [31:0]        mant_val;
    logic [31:0]        base;
    logic [63:0]        prod;
    logic [6:0]         k_off;
    logic [6:0]         sh_rnd;
    logic [66:0]        left;
    logic [63:0]        right;
    logic [64:0]        rnd;
    logic [31:0]        res_price;
    logic               res_sat;
    logic [15:0]        cnt_next;
    logic               last;

    gbm_mul u_mul (
        .i_clk  (i_clk),
        .i_req  (mul_req),
        .o_prod (mul_prod)
    );

    gbm_pow2_rom u_rom (
        .i_clk  (i_clk),
        .i_addr (rom_addr),
        .o_data (rom_data)
    );

    assign in_xfer  = i_sample.valid && i_sample.ready;
    assign out_free = !r_out_valid || o_result.ready;
    assign out_load = (r_state == S_SHIFT) && out_free;

    assign i_sample.ready      = (r_state == S_IDLE);
    assign o_result.valid      = r_out_valid;
    assign o_result.price      = r_out_price;
    assign o_result.step_index = r_out_step;
    assign o_result.last_of_path = r_out_last;
    assign o_result.saturated  = r_out_sat;

    // exponent argument: drift + floor(diffusion * z / 2^12), clamped
    assign z_ext   = {r_z[15], r_z};
    assign z_abs   = r_z[15] ? (~z_ext + 17'd1) : z_ext;
    assign prod_s  = r_z[15] ? -$signed({1'b0, mul_prod[46:0]}) : $signed({1'b0, mul_prod[46:0]});
    assign prod_sh = prod_s >>> 12;
    assign w_sum   = $signed({{5{r_drift[31]}}, r_drift}) + $signed(prod_sh[36:0]);
    assign w_abs   = w_sum[36] ? -w_sum : w_sum;

    always_comb begin
        if (w_sum > W_LIMIT) begin
            w_neg = 1'b0;
            w_mag = W_LIMIT[32:0];
        end else if (w_sum < W_LIMIT_NEG) begin
            w_neg = 1'b1;
            w_mag = W_LIMIT[32:0];
        end else begin
            w_neg = w_sum[36];
            w_mag = w_abs[32:0];
        end
    end

    // split t = w * log2(e) into integer k and fraction f
    assign k_mag = mul_prod[64:58];
    assign f_raw = mul_prod[57:30];
    assign k_val = r_neg ? ($signed(-k_mag) - $signed({6'd0, (f_raw != '0)})) : $signed(k_mag);
    assign f_val = r_neg ? (~f_raw + 28'd1) : f_raw;

    assign tbl_idx  = {1'b0, r_f[27 -: TBL_IDX_W]};
    assign rom_addr = (r_state == S_ROM_HI) ? (tbl_idx + TBL_ADDR_W'(1)) : tbl_idx;
    assign tbl_diff = rom_data - r_lo;
    assign mant_val = r_lo + mul_prod[FRAC_W +: 32];

    assign base = (r_step_cnt == '0) ? r_init_price : r_cur_price;

    // scale by 2^(k-30) with round half up, saturating
    assign prod   = mul_prod[63:0];
    assign k_off  = r_k - 7'sd30;
    assign sh_rnd = 7'sd29 - r_k;
    assign left   = {3'b000, prod} << k_off[1:0];
    assign right  = prod >> sh_rnd[5:0];
    assign rnd    = ({1'b0, right} + 65'd1) >> 1;

    always_comb begin
        if (r_k >= 7'sd30) begin
            res_sat   = |left[66:32];
            res_price = res_sat ? PRICE_MAX : left[31:0];
        end else begin
            res_sat   = |rnd[64:32];
            res_price = res_sat ? PRICE_MAX : rnd[31:0];
        end
    end

    assign cnt_next = r_step_cnt + 16'd1;
    assign last     = (cnt_next >= r_steps);

    always_comb begin
        n_state = r_state;
        mul_req = '0;
        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_state = S_DIFF;
                end
            end
            S_DIFF: begin
                mul_req.en = 1'b1;
                mul_req.a  = {2'b00, r_diffusion};
                mul_req.b  = {15'd0, z_abs};
                n_state    = S_WSUM;
            end
            S_WSUM: begin
                n_state = S_LOG;
            end
            S_LOG: begin
                mul_req.en = 1'b1;
                mul_req.a  = r_mag;
                mul_req.b  = {1'b0, LOG2E_Q30};
                n_state    = S_SPLIT;
            end
            S_SPLIT: begin
                n_state = S_ROM_LO;
            end
            S_ROM_LO: begin
                n_state = S_ROM_HI;
            end
            S_ROM_HI: begin
                n_state = S_INTERP;
            end
            S_INTERP: begin
                mul_req.en = 1'b1;
                mul_req.a  = {1'b0, tbl_diff};
                mul_req.b  = {{(MUL_B_W-FRAC_W){1'b0}}, r_f[FRAC_W-1:0]};
                n_state    = S_MANT;
            end
            S_MANT: begin
                n_state = S_PRICE;
            end
            S_PRICE: begin
                mul_req.en = 1'b1;
                mul_req.a  = {1'b0, base};
                mul_req.b  = r_mant;
                n_state    = S_SHIFT;
            end
            S_SHIFT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_out_valid  <= 1'b0;
            r_step_cnt   <= '0;
            r_cur_price  <= INIT_PRICE_RST;
            r_init_price <= INIT_PRICE_RST;
            r_drift      <= '0;
            r_diffusion  <= '0;
            r_steps      <= STEPS_RST;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_INIT_PRICE: r_init_price <= i_cfg_data;
                    CFG_DRIFT:      r_drift      <= $signed(i_cfg_data);
                    CFG_DIFFUSION:  r_diffusion  <= i_cfg_data[30:0];
                    CFG_STEPS:      r_steps      <= i_cfg_data[15:0];
                    default:        r_steps      <= r_steps;
                endcase
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
                if (last) begin
                    r_step_cnt  <= '0;
                    r_cur_price <= r_init_price;
                end else begin
                    r_step_cnt  <= cnt_next;
                    r_cur_price <= res_price;
                end
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    r_z <= i_sample.normal_sample;
                end
            end
            S_WSUM: begin
                r_neg <= w_neg;
                r_mag <= w_mag;
            end
            S_SPLIT: begin
                r_k <= k_val;
                r_f <= f_val;
            end
            S_ROM_HI: begin
                r_lo <= rom_data;
            end
            S_MANT: begin
                r_mant <= mant_val;
            end
            default: begin
                r_lo <= r_lo;
            end
        endcase
        if (out_load) begin
            r_out_price <= res_price;
            r_out_step  <= cnt_next;
            r_out_last  <= last;
            r_out_sat   <= res_sat;
        end
    end

`ifndef SYNTHESIS
    a_busy_after_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> !i_sample.ready)
        else $error("sample taken while a step is in progress");

    a_load_not_with_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> !in_xfer)
        else $error("result load overlaps a sample transfer");

    a_sat_is_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && o_result.saturated |-> o_result.price == PRICE_MAX)
        else $error("saturated flag without maximum price");
`endif

endmodule

`default_nettype wire
